[sv/nsfe_pkg.sv]
// nsfe_pkg: shared types and constants for the nmea sentence field extractor
// no dependencies; used by every module of the block

package nsfe_pkg;

	// staging store geometry: one row per captured field
	localparam int SLOT_COUNT = 11;
	localparam int SLOT_LEN   = 11;
	localparam int ROW_W      = 4;
	localparam int LANE_W     = 4;
	localparam int HEADER_LEN = 5;

	// ascii codes
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// sentence headers
	localparam logic [39:0] HDR_ZDA = 40'h474E5A4441;
	localparam logic [39:0] HDR_VTG = 40'h474E565447;
	localparam logic [39:0] HDR_GGA = 40'h474E474741;

	// first result code of each sentence type
	localparam logic [3:0] CODE_ZDA = 4'd0;
	localparam logic [3:0] CODE_VTG = 4'd4;
	localparam logic [3:0] CODE_GGA = 4'd5;

	// one character write into the staging store
	typedef struct packed {
		logic              en;
		logic [ROW_W-1:0]  row;
		logic [LANE_W-1:0] lane;
		logic [7:0]        data;
	} stg_wr_t;

	// request to emit a run of fields at line feed
	typedef struct packed {
		logic              go;
		logic [ROW_W-1:0]  first_row;
		logic [3:0]        first_code;
		logic [2:0]        count;
	} run_req_t;

endpackage

[sv/nsfe_stage_mem.sv]
// nsfe_stage_mem: staging store for captured field text, one row per field
// depends on nsfe_pkg; fill counts stand in for the space refill at each dollar

module nsfe_stage_mem #(
	parameter int FIELD_CHARS = 11
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 clr,
	input  nsfe_pkg::stg_wr_t                    wr,
	input  logic                                 rd_en,
	input  logic [nsfe_pkg::ROW_W-1:0]           rd_row,
	output logic [8*nsfe_pkg::SLOT_LEN-1:0]      rd_text
);

	localparam int RowBits = 8 * FIELD_CHARS;

	logic [RowBits-1:0]              mem_q [nsfe_pkg::SLOT_COUNT];
	logic [nsfe_pkg::LANE_W-1:0]     fill_q [nsfe_pkg::SLOT_COUNT];
	logic [RowBits-1:0]              rd_data_s1;
	logic [nsfe_pkg::LANE_W-1:0]     rd_fill_s1;

	// byte lane write, registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			for (int i = 0; i < FIELD_CHARS; i++) begin
				if (wr.lane == nsfe_pkg::LANE_W'(i)) begin
					mem_q[wr.row][8*i +: 8] <= wr.data;
				end
			end
		end
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_row];
			rd_fill_s1 <= fill_q[rd_row];
		end
	end

	// characters are written in order, so a count per row marks what is live
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < nsfe_pkg::SLOT_COUNT; r++) begin
				fill_q[r] <= '0;
			end
		end else if (clr) begin
			for (int r = 0; r < nsfe_pkg::SLOT_COUNT; r++) begin
				fill_q[r] <= '0;
			end
		end else if (wr.en) begin
			fill_q[wr.row] <= wr.lane + nsfe_pkg::LANE_W'(1);
		end
	end

	// first character in the top byte; unwritten characters read as spaces
	for (genvar g = 0; g < nsfe_pkg::SLOT_LEN; g++) begin : g_lane
		if (g < FIELD_CHARS) begin : g_live
			assign rd_text[8*(nsfe_pkg::SLOT_LEN-1-g) +: 8] =
				(rd_fill_s1 > nsfe_pkg::LANE_W'(g)) ? rd_data_s1[8*g +: 8]
				                                    : nsfe_pkg::CH_SPACE;
		end else begin : g_pad
			assign rd_text[8*(nsfe_pkg::SLOT_LEN-1-g) +: 8] = nsfe_pkg::CH_SPACE;
		end
	end

endmodule

[sv/nsfe_line_ctl.sv]
// nsfe_line_ctl: per-byte line parser (header, position, field and char counters)
// depends on nsfe_pkg; drives staging store writes and run requests at line feed

module nsfe_line_ctl #(
	parameter int FIELD_CHARS = 11,
	parameter int MAX_LINE    = 80
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            rx_byte,
	output logic                  clr,
	output nsfe_pkg::stg_wr_t     wr,
	output nsfe_pkg::run_req_t    run_req
);

	localparam int PosW = $clog2(MAX_LINE + 1);

	logic                         active_q;
	logic [39:0]                  hdr_q;
	logic [PosW-1:0]              pos_q;
	logic [3:0]                   fnum_q;
	logic [nsfe_pkg::LANE_W-1:0]  cif_q;
	logic                         ended_q;

	logic is_dollar, is_lf, is_end, is_comma, live, in_hdr, at_sep, cap_ok;

	always_comb begin
		is_dollar = rx_byte == nsfe_pkg::CH_DOLLAR;
		is_lf     = rx_byte == nsfe_pkg::CH_LF;
		is_end    = (rx_byte == nsfe_pkg::CH_STAR) || (rx_byte == nsfe_pkg::CH_CR);
		is_comma  = rx_byte == nsfe_pkg::CH_COMMA;
		live      = take && !is_dollar && !is_lf && active_q && !ended_q
		            && (pos_q < PosW'(MAX_LINE));
		in_hdr    = pos_q < PosW'(nsfe_pkg::HEADER_LEN);
		at_sep    = pos_q == PosW'(nsfe_pkg::HEADER_LEN);
		cap_ok    = (fnum_q < 4'(nsfe_pkg::SLOT_COUNT))
		            && (cif_q < nsfe_pkg::LANE_W'(FIELD_CHARS));

		clr     = take && is_dollar;

		wr.en   = live && !is_end && !in_hdr && !at_sep && !is_comma && cap_ok;
		wr.row  = fnum_q[nsfe_pkg::ROW_W-1:0];
		wr.lane = cif_q;
		wr.data = rx_byte;

		run_req.go         = 1'b0;
		run_req.first_row  = '0;
		run_req.first_code = nsfe_pkg::CODE_ZDA;
		run_req.count      = 3'd0;
		if (take && is_lf && active_q) begin
			if (hdr_q == nsfe_pkg::HDR_ZDA) begin
				run_req.go         = 1'b1;
				run_req.first_row  = nsfe_pkg::ROW_W'(0);
				run_req.first_code = nsfe_pkg::CODE_ZDA;
				run_req.count      = 3'd4;
			end else if (hdr_q == nsfe_pkg::HDR_VTG) begin
				run_req.go         = 1'b1;
				run_req.first_row  = nsfe_pkg::ROW_W'(6);
				run_req.first_code = nsfe_pkg::CODE_VTG;
				run_req.count      = 3'd1;
			end else if (hdr_q == nsfe_pkg::HDR_GGA) begin
				run_req.go         = 1'b1;
				run_req.first_row  = nsfe_pkg::ROW_W'(1);
				run_req.first_code = nsfe_pkg::CODE_GGA;
				run_req.count      = 3'd6;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			hdr_q    <= '0;
			pos_q    <= '0;
			fnum_q   <= '0;
			cif_q    <= '0;
			ended_q  <= 1'b0;
		end else if (take && is_dollar) begin
			active_q <= 1'b1;
			hdr_q    <= '0;
			pos_q    <= '0;
			fnum_q   <= '0;
			cif_q    <= '0;
			ended_q  <= 1'b0;
		end else if (take && is_lf) begin
			active_q <= 1'b0;
		end else if (live) begin
			pos_q <= pos_q + PosW'(1);
			if (is_end) begin
				ended_q <= 1'b1;
			end else if (in_hdr) begin
				hdr_q <= {hdr_q[31:0], rx_byte};
			end else if (at_sep) begin
				// separator after the header is skipped
			end else if (is_comma) begin
				if (fnum_q != 4'hF) begin
					fnum_q <= fnum_q + 4'd1;
				end
				cif_q <= '0;
			end else if (cap_ok) begin
				cif_q <= cif_q + nsfe_pkg::LANE_W'(1);
			end
		end
	end

endmodule

[sv/nsfe_emit.sv]
// nsfe_emit: result sequencer, reads one staging row per result into the output register
// depends on nsfe_pkg; drives the read port of nsfe_stage_mem

module nsfe_emit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  nsfe_pkg::run_req_t                run_req,
	output logic                              busy,
	output logic                              rd_en,
	output logic [nsfe_pkg::ROW_W-1:0]        rd_row,
	input  logic [8*nsfe_pkg::SLOT_LEN-1:0]   rd_text,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [3:0]                        field_code,
	output logic [63:0]                       text_head,
	output logic [23:0]                       text_tail,
	output logic                              last_of_run
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} emit_state_t;

	emit_state_t                  state_q;
	logic [nsfe_pkg::ROW_W-1:0]   row_q;
	logic [3:0]                   code_q;
	logic [2:0]                   left_q;
	logic                         rd_s1;
	logic [3:0]                   code_s1;
	logic                         last_s1;
	logic                         out_valid_q;
	logic [3:0]                   code_out_q;
	logic [63:0]                  head_q;
	logic [23:0]                  tail_q;
	logic                         last_q;

	// one read in flight, and only when the output register is free next cycle
	assign rd_en  = (state_q == ST_RUN) && !rd_s1 && (!out_valid_q || out_ready);
	assign rd_row = row_q;
	assign busy   = state_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			code_q      <= '0;
			left_q      <= '0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (run_req.go) begin
						state_q <= ST_RUN;
						row_q   <= run_req.first_row;
						code_q  <= run_req.first_code;
						left_q  <= run_req.count;
					end
				end
				ST_RUN: begin
					if (rd_en) begin
						row_q  <= row_q + nsfe_pkg::ROW_W'(1);
						code_q <= code_q + 4'd1;
						left_q <= left_q - 3'd1;
						if (left_q == 3'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (rd_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			code_s1 <= code_q;
			last_s1 <= left_q == 3'd1;
		end
		if (rd_s1) begin
			code_out_q <= code_s1;
			head_q     <= rd_text[87:24];
			tail_q     <= rd_text[23:0];
			last_q     <= last_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign field_code  = code_out_q;
	assign text_head   = head_q;
	assign text_tail   = tail_q;
	assign last_of_run = last_q;

endmodule

[sv/nmea_sentence_field_extractor_core.sv]
// nmea_sentence_field_extractor_core: top level of the nmea sentence field extractor
// depends on nsfe_pkg, nsfe_stage_mem, nsfe_line_ctl and nsfe_emit

// Takes received ascii bytes, one per input transfer, and pulls selected fields out of
// GNZDA, GNVTG and GNGGA sentences. A dollar opens a line, the next five characters are
// the header, the character after it is skipped, and comma-separated fields are staged
// into a small synchronous memory, one row of up to FIELD_CHARS characters per field
// (fields 0 to 10; longer text is cut, later fields are not kept). A star or CR closes
// the data part, bytes at line position MAX_LINE or beyond are dropped. At line feed the
// block gives one result transfer per field of the sentence type: ZDA time, day, month
// and year as codes 0 to 3, VTG km/h as code 4, GGA latitude, N/S, longitude, E/W, fix
// and satellite count as codes 5 to 10; text_head holds characters 1 to 8 and text_tail
// characters 9 to 11, first character in the top byte, missing characters as spaces,
// and last_of_run marks the final result. A line feed with no open line or an unknown
// header gives nothing. Bytes are taken one per cycle while no run is being read out,
// and in_ready stays high for back-to-back bytes. A line feed that starts a run
// holds in_ready low while the rows are read out: each result costs one memory read and
// a pass through the registered read data, and the next read waits until that data has
// moved on and the output register can take it, so a run also stretches while out_ready
// is held low; in_ready rises once the last read is issued. A result waiting in the
// output register does not stop the next byte from being taken. No clearing pass is
// needed after reset: per-row fill counts, cleared at each dollar, decide which staged
// characters are live.

module nmea_sentence_field_extractor_core #(
	parameter int FIELD_CHARS = 11,
	parameter int MAX_LINE    = 80
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  field_code,
	output logic [63:0] text_head,
	output logic [23:0] text_tail,
	output logic        last_of_run
);

	logic                               take;
	logic                               busy;
	logic                               clr;
	nsfe_pkg::stg_wr_t                  wr;
	nsfe_pkg::run_req_t                 run_req;
	logic                               rd_en;
	logic [nsfe_pkg::ROW_W-1:0]         rd_row;
	logic [8*nsfe_pkg::SLOT_LEN-1:0]    rd_text;

	// bytes are taken whenever no run is being read out
	assign in_ready = !busy;
	assign take     = in_valid && in_ready;

	// parser: header, counters, character writes and run requests
	nsfe_line_ctl #(
		.FIELD_CHARS (FIELD_CHARS),
		.MAX_LINE    (MAX_LINE)
	) u_line_ctl (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx_byte),
		.clr     (clr),
		.wr      (wr),
		.run_req (run_req)
	);

	// staged field text, one row per field
	nsfe_stage_mem #(
		.FIELD_CHARS (FIELD_CHARS)
	) u_stage_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (clr),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_row  (rd_row),
		.rd_text (rd_text)
	);

	// read-out sequencer and output register
	nsfe_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.run_req     (run_req),
		.busy        (busy),
		.rd_en       (rd_en),
		.rd_row      (rd_row),
		.rd_text     (rd_text),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.field_code  (field_code),
		.text_head   (text_head),
		.text_tail   (text_tail),
		.last_of_run (last_of_run)
	);

endmodule

[tb/tb_top.sv]
// tb_top: self-checking testbench for nmea_sentence_field_extractor_core
// depends on nsfe_pkg and the core; holds its own line tracker to predict field results

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FIELD_CHARS   = 11;
	localparam int MAX_LINE      = 80;
	localparam int STAGE_SIZE    = nsfe_pkg::SLOT_COUNT * nsfe_pkg::SLOT_LEN;
	localparam int FIELD_NUM_MAX = 15;

	// which staged field feeds which result code
	localparam int ZDA_FIELDS     = 4;
	localparam int VTG_KMH_SLOT   = 6;
	localparam int GGA_FIRST_SLOT = 1;
	localparam int GGA_FIELDS     = 6;

	localparam logic [7:0] CH_ZERO = 8'h30;

	// run length
	localparam int RANDOM_BYTES   = 30;
	localparam int RANDOM_RESULTS = 6;
	localparam int MAX_GAP        = 20;
	localparam int DRAIN_CYCLES   = 32;
	localparam int CYCLE_LIMIT    = 200000;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	// one field result as it leaves the block
	typedef struct packed {
		logic [3:0]  code;
		logic [63:0] head;
		logic [23:0] tail;
		logic        is_last;
	} field_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  field_code;
	logic [63:0] text_head;
	logic [23:0] text_tail;
	logic        last_of_run;

	// line tracker state, mirrors what the block keeps per sentence
	logic        line_open;
	logic [39:0] header_seen;
	int          line_pos;
	int          field_idx;
	int          char_idx;
	logic        data_closed;
	logic [7:0]  staged [0:STAGE_SIZE-1];

	field_result_t expected_fields [$];

	int fail_count      = 0;
	int bytes_sent      = 0;
	int fields_promised = 0;
	int send_pct        = 0;
	int recv_pct        = 0;

	always #5 clk = ~clk;

	nmea_sentence_field_extractor_core #(
		.FIELD_CHARS (FIELD_CHARS),
		.MAX_LINE    (MAX_LINE)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.field_code  (field_code),
		.text_head   (text_head),
		.text_tail   (text_tail),
		.last_of_run (last_of_run)
	);

	// idling percentages for each phase of the run
	function automatic void set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_SENDER: begin
				send_pct = 55;
				recv_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_pct = 0;
				recv_pct = 55;
			end
			IDLE_BOTH: begin
				send_pct = 8;
				recv_pct = 8;
			end
			default: begin
				send_pct = 0;
				recv_pct = 0;
			end
		endcase
	endfunction

	// receiver side: random back-pressure, sampled by the block after the edge
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_pct);

	// state after reset, also what the tracker starts from
	task automatic clear_line_tracker();
		line_open   = 1'b0;
		header_seen = '0;
		line_pos    = 0;
		field_idx   = 0;
		char_idx    = 0;
		data_closed = 1'b0;
		foreach (staged[i])
			staged[i] = nsfe_pkg::CH_SPACE;
	endtask

	// queue one field result built from a staged slot
	task automatic promise_field(input int code, input int slot, input logic is_last);
		field_result_t r;
		r.code    = 4'(code);
		r.head    = '0;
		r.tail    = '0;
		r.is_last = is_last;
		for (int i = 0; i < 8; i++)
			r.head = {r.head[55:0], staged[slot * nsfe_pkg::SLOT_LEN + i]};
		for (int i = 8; i < nsfe_pkg::SLOT_LEN; i++)
			r.tail = {r.tail[15:0], staged[slot * nsfe_pkg::SLOT_LEN + i]};
		expected_fields.push_back(r);
		fields_promised++;
	endtask

	// advance the tracker by one accepted byte and queue the results it causes
	task automatic track_byte(input logic [7:0] b);
		if (b == nsfe_pkg::CH_DOLLAR) begin
			// a dollar restarts the line from anywhere
			clear_line_tracker();
			line_open = 1'b1;
		end else if (b == nsfe_pkg::CH_LF) begin
			if (line_open) begin
				line_open = 1'b0;
				if (header_seen == nsfe_pkg::HDR_ZDA) begin
					for (int i = 0; i < ZDA_FIELDS; i++)
						promise_field(nsfe_pkg::CODE_ZDA + i, i, i == ZDA_FIELDS - 1);
				end else if (header_seen == nsfe_pkg::HDR_VTG) begin
					promise_field(nsfe_pkg::CODE_VTG, VTG_KMH_SLOT, 1'b1);
				end else if (header_seen == nsfe_pkg::HDR_GGA) begin
					for (int i = 0; i < GGA_FIELDS; i++)
						promise_field(nsfe_pkg::CODE_GGA + i, GGA_FIRST_SLOT + i,
							i == GGA_FIELDS - 1);
				end
			end
		end else if (line_open && !data_closed && line_pos < MAX_LINE) begin
			if (b == nsfe_pkg::CH_STAR || b == nsfe_pkg::CH_CR) begin
				data_closed = 1'b1;
			end else if (line_pos < nsfe_pkg::HEADER_LEN) begin
				header_seen = {header_seen[31:0], b};
			end else if (line_pos == nsfe_pkg::HEADER_LEN) begin
				// separator after the header is skipped whatever it is
			end else if (b == nsfe_pkg::CH_COMMA) begin
				if (field_idx < FIELD_NUM_MAX)
					field_idx++;
				char_idx = 0;
			end else if (field_idx < nsfe_pkg::SLOT_COUNT && char_idx < FIELD_CHARS) begin
				staged[field_idx * nsfe_pkg::SLOT_LEN + char_idx] = b;
				char_idx++;
			end
			line_pos++;
		end
	endtask

	// one input transfer; valid stays up across back-to-back bytes
	// in_ready is sampled at the falling edge ahead of the edge that takes the byte
	task automatic send_byte(input logic [7:0] b);
		int gap;
		logic taken;
		in_valid <= 1'b1;
		rx_byte  <= b;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		bytes_sent++;
		track_byte(b);
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// any byte that is not a delimiter, at least half of them digits
	function automatic logic [7:0] rand_text_char();
		logic [7:0] c;
		if ($urandom_range(1) == 0)
			return CH_ZERO + 8'($urandom_range(9));
		do
			c = 8'($urandom_range(255));
		while (c == nsfe_pkg::CH_DOLLAR || c == nsfe_pkg::CH_LF || c == nsfe_pkg::CH_COMMA
			|| c == nsfe_pkg::CH_CR || c == nsfe_pkg::CH_STAR);
		return c;
	endfunction

	// checker: every result transfer against the oldest prediction
	// sampled at the falling edge ahead of the edge that takes the result
	always @(negedge clk) begin : check_results
		field_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_fields.size() == 0) begin
				$error("unexpected result transfer: field_code %0d", field_code);
				fail_count++;
			end else begin
				want = expected_fields.pop_front();
				if (field_code !== want.code) begin
					$error("field_code: expected %0d, actual %0d", want.code, field_code);
					fail_count++;
				end
				if (text_head !== want.head) begin
					$error("text_head: expected %h, actual %h", want.head, text_head);
					fail_count++;
				end
				if (text_tail !== want.tail) begin
					$error("text_tail: expected %h, actual %h", want.tail, text_tail);
					fail_count++;
				end
				if (last_of_run !== want.is_last) begin
					$error("last_of_run: expected %0b, actual %0b", want.is_last, last_of_run);
					fail_count++;
				end
			end
		end
	end

	// line feeds and stray bytes with no open line, and an empty line, give nothing
	task automatic test_stray_bytes();
		send_text("\n");
		send_text("GNZDA,1,2,3,4\n");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("$\n");
	endtask

	// each sentence type once, with the byte extremes in captured text
	task automatic test_sentence_types();
		send_text("$GNZDA,235959.99,");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text(",,9*4A\015\n");
		send_text("$GNVTG,,T,,M,0.1,N,12345678901234,K\n");
		send_text("$GNGGA,4807.038,N,01131.000,E,1,08,0.9\015\n");
	endtask

	// short, unknown and cut headers, early star or cr, odd separator
	task automatic test_headers_and_ends();
		send_text("$GNZDB,1,2,3,4\n");
		send_text("$GN\n");
		send_text("$GNZ*A,1,2,3\n");
		send_text("$GNZDA*,1,2\n");
		send_text("$GNGGA,1,2\015,3,4\n");
		send_text("$GNVTGx1,2,3,4,5,6,7\n");
		send_text("$GNVTG,1,2$GNZDA,a,b,c,d\n");
	endtask

	// more than eleven fields and a line running past the position limit
	task automatic test_long_lines();
		send_text("$GNGGA,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16,17\n");
		// field 1 fills the line up to the limit, the comma at the last slot still counts
		send_text("$GNZDA,1,");
		repeat (71) send_byte("x");
		send_text(",Z,Q\n");
	endtask

	// random sentences with random content, plus noise and broken lines
	task automatic send_random_line();
		int kind;
		int nfields;
		int flen;
		int ending;
		logic [39:0] hdr;
		kind = $urandom_range(99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
			return;
		end
		case ($urandom_range(2))
			0: hdr = nsfe_pkg::HDR_ZDA;
			1: hdr = nsfe_pkg::HDR_VTG;
			default: hdr = nsfe_pkg::HDR_GGA;
		endcase
		if (kind < 15)
			hdr[8 * $urandom_range(4) +: 8] = rand_text_char();
		send_byte(nsfe_pkg::CH_DOLLAR);
		for (int i = nsfe_pkg::HEADER_LEN - 1; i >= 0; i--)
			send_byte(hdr[8 * i +: 8]);
		send_byte(($urandom_range(9) == 0) ? rand_text_char() : nsfe_pkg::CH_COMMA);
		nfields = ($urandom_range(9) == 0) ? $urandom_range(0, 16) : $urandom_range(3, 12);
		for (int f = 0; f < nfields; f++) begin
			if (f > 0)
				send_byte(nsfe_pkg::CH_COMMA);
			flen = ($urandom_range(9) == 0) ? $urandom_range(0, 14) : $urandom_range(0, 4);
			repeat (flen) send_byte(rand_text_char());
		end
		ending = $urandom_range(9);
		if (ending < 5) begin
			send_byte(nsfe_pkg::CH_STAR);
			send_byte(rand_text_char());
			send_byte(rand_text_char());
			send_byte(nsfe_pkg::CH_CR);
			send_byte(nsfe_pkg::CH_LF);
		end else if (ending < 7) begin
			send_byte(nsfe_pkg::CH_CR);
			send_byte(nsfe_pkg::CH_LF);
		end else if (ending < 8) begin
			send_byte(nsfe_pkg::CH_LF);
		end else if (ending < 9) begin
			// abandoned line, the next dollar takes over
		end else begin
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
			send_byte(nsfe_pkg::CH_LF);
		end
	endtask

	// idling phases rotate line by line
	task automatic test_random_traffic();
		int start_bytes;
		int start_fields;
		int line_no;
		start_bytes  = bytes_sent;
		start_fields = fields_promised;
		line_no      = 0;
		while (bytes_sent - start_bytes < RANDOM_BYTES
				|| fields_promised - start_fields < RANDOM_RESULTS) begin
			set_idle(idle_mode_t'(line_no % 4));
			send_random_line();
			line_no++;
		end
		set_idle(IDLE_NONE);
	endtask

	// watchdog on the whole run
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		rx_byte  = '0;
		clear_line_tracker();
		set_idle(IDLE_NONE);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		set_idle(IDLE_NONE);
		test_stray_bytes();
		set_idle(IDLE_SENDER);
		test_sentence_types();
		set_idle(IDLE_RECEIVER);
		test_headers_and_ends();
		set_idle(IDLE_BOTH);
		test_long_lines();
		test_random_traffic();

		in_valid <= 1'b0;
		while (expected_fields.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[sim.f]
sv/nsfe_pkg.sv
sv/nsfe_stage_mem.sv
sv/nsfe_line_ctl.sv
sv/nsfe_emit.sv
sv/nmea_sentence_field_extractor_core.sv
tb/tb_top.sv
